@@ rtl/dmare_pkg.sv @@
// Package for the DMA register engine: operation, access and error codes,
// register indexes, command bytes, word structs and small helper functions.
// No dependencies.
package dmare_pkg;

  // Operation carried by an input word
  typedef enum logic [1:0] {
    OP_CTRL  = 2'd0,
    OP_READY = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Bus access requested by a result word
  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_MEM_RD = 3'd1,
    ACC_A_RD   = 3'd2,
    ACC_B_RD   = 3'd3,
    ACC_MEM_WR = 3'd4,
    ACC_A_WR   = 3'd5,
    ACC_B_WR   = 3'd6
  } access_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BASE = 2'd1,
    ERR_CMD  = 2'd2,
    ERR_MODE = 2'd3
  } err_t;

  // Register file indexes held in the follow-on queue
  localparam logic [5:0] IDX_A_LO      = 6'd1;
  localparam logic [5:0] IDX_A_HI      = 6'd2;
  localparam logic [5:0] IDX_LEN_LO    = 6'd3;
  localparam logic [5:0] IDX_LEN_HI    = 6'd4;
  localparam logic [5:0] IDX_A_TIME    = 6'd9;
  localparam logic [5:0] IDX_B_TIME    = 6'd17;
  localparam logic [5:0] IDX_MASK      = 6'd25;
  localparam logic [5:0] IDX_MATCH     = 6'd26;
  localparam logic [5:0] IDX_B_LO      = 6'd33;
  localparam logic [5:0] IDX_B_HI      = 6'd34;
  localparam logic [5:0] IDX_INT_CTRL  = 6'd35;
  localparam logic [5:0] IDX_VECTOR    = 6'd36;
  localparam logic [5:0] IDX_PULSE     = 6'd37;
  localparam logic [5:0] IDX_READ_MASK = 6'd49;

  // WR6 command bytes
  localparam logic [7:0] CMD_LOAD      = 8'hCF;
  localparam logic [7:0] CMD_ENABLE    = 8'h87;
  localparam logic [7:0] CMD_DISABLE   = 8'h83;
  localparam logic [7:0] CMD_READ_MASK = 8'hBB;
  localparam logic [7:0] CMD_NOP       = 8'hC3;

  // Base byte decode masks and patterns
  localparam logic [7:0] MASK_WR12  = 8'h87;
  localparam logic [7:0] PAT_WR2    = 8'h00;
  localparam logic [7:0] PAT_WR1    = 8'h04;
  localparam logic [7:0] MASK_WR346 = 8'h83;
  localparam logic [7:0] PAT_WR3    = 8'h80;
  localparam logic [7:0] PAT_WR4    = 8'h81;
  localparam logic [7:0] PAT_WR6    = 8'h83;
  localparam logic [7:0] MASK_WR5   = 8'hC7;
  localparam logic [7:0] PAT_WR5    = 8'h82;

  localparam logic [1:0] MODE_TRANSFER = 2'd1;
  localparam int unsigned FOLLOW_DEPTH = 4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data;
    logic       ready_level;
    logic [7:0] read_data;
  } item_t;

  typedef struct packed {
    access_t     access;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        halt;
    logic        block_done;
    err_t        error;
  } result_t;

  // Cycle length of a port from its timing byte: 4 down to 1
  function automatic logic [2:0] cycle_len(input logic [7:0] timing);
    cycle_len = 3'd4 - {1'b0, timing[1:0]};
  endfunction

  // Address step from a port byte: minus one, plus one or fixed
  function automatic logic [15:0] addr_step(input logic [7:0] port);
    case (port[5:4])
      2'b00:   addr_step = 16'hFFFF;
      2'b01:   addr_step = 16'h0001;
      default: addr_step = 16'h0000;
    endcase
  endfunction

endpackage

@@ rtl/dmare_in_reg.sv @@
// Input register for the DMA register engine: holds one input word until
// the engine takes it. Depends on dmare_pkg.
module dmare_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dmare_pkg::item_t in_item,
  input  logic            take_ok,
  output logic            item_valid,
  output dmare_pkg::item_t item
);
  import dmare_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept, take;

  // Stall only while a held word cannot move on
  assign take     = valid_r & take_ok;
  assign in_stall = valid_r & ~take_ok;
  assign accept   = in_valid & ~in_stall;
  assign valid_nxt = accept | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/dmare_core.sv @@
// Register engine core: control byte decode, follow-on queue, ready and
// enable state, address and count stepping, one result per word.
// Depends on dmare_pkg.
module dmare_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  dmare_pkg::item_t   item,
  output dmare_pkg::result_t result
);
  import dmare_pkg::*;

  // Stored registers that the datapath reads
  logic [7:0] wr0_r, wr0_nxt, wr1_r, wr1_nxt, wr2_r, wr2_nxt, wr5_r, wr5_nxt;
  logic [7:0] a_lo_r, a_lo_nxt, a_hi_r, a_hi_nxt;
  logic [7:0] len_lo_r, len_lo_nxt, len_hi_r, len_hi_nxt;
  logic [7:0] b_lo_r, b_lo_nxt, b_hi_r, b_hi_nxt;
  logic [7:0] a_time_r, a_time_nxt, b_time_r, b_time_nxt;

  logic [5:0] follow_r   [FOLLOW_DEPTH];
  logic [5:0] follow_nxt [FOLLOW_DEPTH];
  logic [2:0] fcount_r, fcount_nxt;
  logic [1:0] fcursor_r, fcursor_nxt;

  logic        enabled_r, enabled_nxt, ready_r, ready_nxt;
  logic [15:0] addr_a_r, addr_a_nxt, addr_b_r, addr_b_nxt, count_r, count_nxt;
  logic        read_phase_r, read_phase_nxt;
  logic [2:0]  cycle_left_r, cycle_left_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic        awaiting_r, awaiting_nxt;

  // Working signals
  logic [3:0] push_en;
  logic [5:0] push_idx [FOLLOW_DEPTH];
  logic       queue_load;
  logic [2:0] push_cnt;
  logic [5:0] fidx;
  logic [2:0] next_cur;
  logic       pend_chk;
  logic [2:0] cl_dec;
  logic       a_src, mode_ok;
  logic [7:0] d;
  result_t    res;

  assign d       = item.data;
  assign a_src   = wr0_r[2];
  assign mode_ok = (wr0_r[1:0] == MODE_TRANSFER);
  assign fidx    = follow_r[fcursor_r];
  assign next_cur = {1'b0, fcursor_r} + 3'd1;
  assign cl_dec  = cycle_left_r - 3'd1;

  // Decode the word and compute next state and result
  always_comb begin
    wr0_nxt = wr0_r;  wr1_nxt = wr1_r;  wr2_nxt = wr2_r;  wr5_nxt = wr5_r;
    a_lo_nxt = a_lo_r;  a_hi_nxt = a_hi_r;
    len_lo_nxt = len_lo_r;  len_hi_nxt = len_hi_r;
    b_lo_nxt = b_lo_r;  b_hi_nxt = b_hi_r;
    a_time_nxt = a_time_r;  b_time_nxt = b_time_r;
    fcount_nxt = fcount_r;  fcursor_nxt = fcursor_r;
    enabled_nxt = enabled_r;  ready_nxt = ready_r;
    addr_a_nxt = addr_a_r;  addr_b_nxt = addr_b_r;  count_nxt = count_r;
    read_phase_nxt = read_phase_r;  cycle_left_nxt = cycle_left_r;
    latch_nxt = awaiting_r ? item.read_data : latch_r;
    awaiting_nxt = 1'b0;
    push_en = 4'b0000;
    for (int i = 0; i < FOLLOW_DEPTH; i++) begin
      push_idx[i] = IDX_A_LO;
    end
    queue_load = 1'b0;
    pend_chk = 1'b0;
    res.access = ACC_NONE;
    res.address = 16'h0000;
    res.write_data = 8'h00;
    res.block_done = 1'b0;
    res.error = ERR_NONE;

    case (op_t'(item.operation))
      OP_CTRL: begin
        if (fcount_r == 3'd0) begin
          // Base byte
          queue_load = 1'b1;
          fcursor_nxt = 2'd0;
          if ((d & MASK_WR12) == PAT_WR2) begin
            wr2_nxt = d;
            push_en[0] = d[6];  push_idx[0] = IDX_B_TIME;
          end else if ((d & MASK_WR12) == PAT_WR1) begin
            wr1_nxt = d;
            push_en[0] = d[6];  push_idx[0] = IDX_A_TIME;
          end else if (!d[7]) begin
            wr0_nxt = d;
            push_en = d[6:3];
            push_idx[0] = IDX_A_LO;    push_idx[1] = IDX_A_HI;
            push_idx[2] = IDX_LEN_LO;  push_idx[3] = IDX_LEN_HI;
          end else if ((d & MASK_WR346) == PAT_WR3) begin
            push_en[1:0] = d[4:3];
            push_idx[0] = IDX_MASK;  push_idx[1] = IDX_MATCH;
          end else if ((d & MASK_WR346) == PAT_WR4) begin
            push_en[2:0] = d[4:2];
            push_idx[0] = IDX_B_LO;  push_idx[1] = IDX_B_HI;
            push_idx[2] = IDX_INT_CTRL;
          end else if ((d & MASK_WR5) == PAT_WR5) begin
            wr5_nxt = d;
          end else if ((d & MASK_WR346) == PAT_WR6) begin
            if (d == CMD_LOAD) begin
              addr_a_nxt = {a_hi_r, a_lo_r};
              addr_b_nxt = {b_hi_r, b_lo_r};
              count_nxt  = {len_hi_r, len_lo_r};
            end else if (d == CMD_DISABLE) begin
              enabled_nxt = 1'b0;
              pend_chk = 1'b1;
            end else if (d == CMD_ENABLE) begin
              enabled_nxt = 1'b1;
              pend_chk = 1'b1;
            end else if (d == CMD_READ_MASK) begin
              push_en[0] = 1'b1;  push_idx[0] = IDX_READ_MASK;
            end else if (d != CMD_NOP) begin
              res.error = ERR_CMD;
            end
          end else begin
            res.error = ERR_BASE;
          end
        end else begin
          // Follow-on byte: store into the queued register
          case (fidx)
            IDX_A_LO:   a_lo_nxt = d;
            IDX_A_HI:   a_hi_nxt = d;
            IDX_LEN_LO: len_lo_nxt = d;
            IDX_LEN_HI: len_hi_nxt = d;
            IDX_A_TIME: a_time_nxt = d;
            IDX_B_TIME: b_time_nxt = d;
            IDX_B_LO:   b_lo_nxt = d;
            IDX_B_HI:   b_hi_nxt = d;
            default:    ;
          endcase
          if (next_cur >= fcount_r) begin
            fcount_nxt = 3'd0;
          end
          fcursor_nxt = next_cur[1:0];
          // Interrupt control replaces the queue with pulse and vector
          if (fidx == IDX_INT_CTRL) begin
            queue_load = 1'b1;
            fcursor_nxt = 2'd0;
            push_en[1:0] = d[4:3];
            push_idx[0] = IDX_PULSE;  push_idx[1] = IDX_VECTOR;
          end
        end
      end
      OP_READY: begin
        ready_nxt = ~(item.ready_level ^ wr5_r[3]);
        pend_chk = 1'b1;
      end
      OP_TICK: begin
        if (ready_r && enabled_r) begin
          cycle_left_nxt = cl_dec;
          if (cl_dec == 3'd0) begin
            if (read_phase_r) begin
              // Read phase from the source port
              if (!mode_ok) begin
                res.error = ERR_MODE;
              end else if (a_src) begin
                res.access = wr1_r[3] ? ACC_A_RD : ACC_MEM_RD;
                res.address = addr_a_r;
                addr_a_nxt = addr_a_r + addr_step(wr1_r);
                awaiting_nxt = 1'b1;
              end else begin
                res.access = wr2_r[3] ? ACC_B_RD : ACC_MEM_RD;
                res.address = addr_b_r;
                addr_b_nxt = addr_b_r + addr_step(wr2_r);
                awaiting_nxt = 1'b1;
              end
              read_phase_nxt = 1'b0;
              cycle_left_nxt = cycle_len(a_src ? a_time_r : b_time_r);
            end else begin
              // Write phase to the destination port
              if (!mode_ok) begin
                res.error = ERR_MODE;
              end else begin
                if (a_src) begin
                  res.access = wr2_r[3] ? ACC_B_WR : ACC_MEM_WR;
                  res.address = addr_b_r;
                  addr_b_nxt = addr_b_r + addr_step(wr2_r);
                end else begin
                  res.access = wr1_r[3] ? ACC_A_WR : ACC_MEM_WR;
                  res.address = addr_a_r;
                  addr_a_nxt = addr_a_r + addr_step(wr1_r);
                end
                res.write_data = latch_nxt;
                count_nxt = count_r - 16'd1;
                res.block_done = (count_r == 16'd0);
              end
              read_phase_nxt = 1'b1;
              cycle_left_nxt = cycle_len(a_src ? b_time_r : a_time_r);
              if (res.block_done) begin
                enabled_nxt = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase

    // Restart the phase sequence when a transfer becomes pending
    if (pend_chk && ready_nxt && enabled_nxt) begin
      read_phase_nxt = 1'b1;
      cycle_left_nxt = cycle_len(a_src ? a_time_r : b_time_r);
    end

    res.halt = ready_nxt & enabled_nxt;
  end

  // Pack queued follow-on indexes in bit order
  always_comb begin
    for (int i = 0; i < FOLLOW_DEPTH; i++) begin
      follow_nxt[i] = follow_r[i];
    end
    push_cnt = 3'd0;
    for (int i = 0; i < FOLLOW_DEPTH; i++) begin
      if (push_en[i]) begin
        follow_nxt[push_cnt[1:0]] = push_idx[i];
        push_cnt = push_cnt + 3'd1;
      end
    end
  end

  // Control and register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr0_r <= '0;  wr1_r <= '0;  wr2_r <= '0;  wr5_r <= '0;
      a_lo_r <= '0;  a_hi_r <= '0;  len_lo_r <= '0;  len_hi_r <= '0;
      b_lo_r <= '0;  b_hi_r <= '0;  a_time_r <= '0;  b_time_r <= '0;
      fcount_r <= '0;  fcursor_r <= '0;
      enabled_r <= 1'b0;  ready_r <= 1'b0;
      addr_a_r <= '0;  addr_b_r <= '0;  count_r <= '0;
      read_phase_r <= 1'b1;  cycle_left_r <= '0;
      latch_r <= '0;  awaiting_r <= 1'b0;
    end else if (fire) begin
      wr0_r <= wr0_nxt;  wr1_r <= wr1_nxt;  wr2_r <= wr2_nxt;  wr5_r <= wr5_nxt;
      a_lo_r <= a_lo_nxt;  a_hi_r <= a_hi_nxt;
      len_lo_r <= len_lo_nxt;  len_hi_r <= len_hi_nxt;
      b_lo_r <= b_lo_nxt;  b_hi_r <= b_hi_nxt;
      a_time_r <= a_time_nxt;  b_time_r <= b_time_nxt;
      fcount_r <= queue_load ? push_cnt : fcount_nxt;
      fcursor_r <= fcursor_nxt;
      enabled_r <= enabled_nxt;  ready_r <= ready_nxt;
      addr_a_r <= addr_a_nxt;  addr_b_r <= addr_b_nxt;  count_r <= count_nxt;
      read_phase_r <= read_phase_nxt;  cycle_left_r <= cycle_left_nxt;
      latch_r <= latch_nxt;  awaiting_r <= awaiting_nxt;
    end
  end

  // Follow-on queue entries, valid only below the fill count
  always_ff @(posedge clk) begin
    if (fire && queue_load) begin
      for (int i = 0; i < FOLLOW_DEPTH; i++) begin
        follow_r[i] <= follow_nxt[i];
      end
    end
  end

  assign result = res;

endmodule

@@ rtl/dmare_out_reg.sv @@
// Result register for the DMA register engine: holds one result word
// while the receiver stalls. Depends on dmare_pkg.
module dmare_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_req,
  input  dmare_pkg::result_t  result,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_stall,
  output dmare_pkg::result_t  out_word
);
  import dmare_pkg::*;

  logic    valid_r, valid_nxt;
  result_t word_r;
  logic    load;

  // Free when empty or being taken this cycle
  assign load_ok   = ~valid_r | ~out_stall;
  assign load      = load_req & load_ok;
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

@@ rtl/dma_controller_register_engine.sv @@
// Top level of the DMA register engine: input register, core, result register.
// Depends on dmare_pkg, dmare_in_reg, dmare_core and dmare_out_reg.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | operation, data, ready_level, read_data
//   out_    | output    | out_valid/out_stall| access, address, write_data, halt,
//           |           |                    | block_done, error
//
// One word per cycle sustained while the receiver does not stall. A word accepted
// sits in the input register; decode and state update then load its result into
// the result register once that register is free. Synchronous active-low reset
// clears the engine state and both valid flags. A stalled result holds the result
// register and, once the input register is full, stalls the input.
module dma_controller_register_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data,
  input  logic        in_ready_level,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_access,
  output logic [15:0] out_address,
  output logic [7:0]  out_write_data,
  output logic        out_halt,
  output logic        out_block_done,
  output logic [1:0]  out_error
);
  import dmare_pkg::*;

  item_t   in_item, item;
  logic    item_valid, load_ok, fire;
  result_t result, out_word;

  assign in_item.operation   = in_operation;
  assign in_item.data        = in_data;
  assign in_item.ready_level = in_ready_level;
  assign in_item.read_data   = in_read_data;

  assign fire = item_valid & load_ok;

  dmare_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take_ok    (load_ok),
    .item_valid (item_valid),
    .item       (item)
  );

  dmare_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  dmare_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_req  (item_valid),
    .result    (result),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_access     = out_word.access;
  assign out_address    = out_word.address;
  assign out_write_data = out_word.write_data;
  assign out_halt       = out_word.halt;
  assign out_block_done = out_word.block_done;
  assign out_error      = out_word.error;

endmodule

@@ rtl/dmare_checker.sv @@
// Port-level checks for the DMA register engine, bound to the top level.
// Depends on dmare_pkg and dma_controller_register_engine.
module dmare_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_access,
  input logic [15:0] out_address,
  input logic [7:0]  out_write_data,
  input logic        out_halt,
  input logic        out_block_done,
  input logic [1:0]  out_error
);
  import dmare_pkg::*;

  // Hold the access, address and write data of a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_access)
      && $stable(out_address) && $stable(out_write_data))
    else $error("result word changed while stalled");

  // A bus access never carries an error
  a_access_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access != ACC_NONE |-> out_error == ERR_NONE)
    else $error("access reported together with an error");

  // End of block is a write that drops halt
  a_done_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_done |-> !out_halt
      && (out_access == ACC_MEM_WR || out_access == ACC_A_WR
          || out_access == ACC_B_WR))
    else $error("block end without a write or with halt held");

  // No access drives no address and no data
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access == ACC_NONE |-> out_address == 16'h0000
      && out_write_data == 8'h00)
    else $error("idle result with address or data");

endmodule

bind dma_controller_register_engine dmare_checker u_dmare_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_access     (out_access),
  .out_address    (out_address),
  .out_write_data (out_write_data),
  .out_halt       (out_halt),
  .out_block_done (out_block_done),
  .out_error      (out_error)
);
